// ----- hdl/mmae_pkg.sv -----
// ----------------------------------------------------------------------------
// mmae_pkg
// shared constants, types and helper functions of the matrix engine
// ----------------------------------------------------------------------------
package mmae_pkg;

  localparam int unsigned MAX_DIM   = 8;
  localparam int unsigned ELEM_BITS = 32;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned REG_W   = 2;

  // input commands
  localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_RUN        = 2'd2;

  // operation register codes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_PROD = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_W-1:0] REG_RIGHT_COLS = 2'd2;
  localparam logic [REG_W-1:0] REG_OPERATION  = 2'd3;

  typedef struct packed {
    logic [3:0] left_rows;
    logic [3:0] inner_size;
    logic [3:0] right_cols;
    logic [1:0] operation;
  } cfg_t;

  typedef struct packed {
    logic                 we_left;
    logic                 we_right;
    logic [ADDR_W-1:0]    waddr;
    logic [ELEM_BITS-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr_left;
    logic [ADDR_W-1:0]    raddr_right;
  } mem_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [3:0] d);
    if (d == 4'd0) begin
      return DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
  endfunction

  // 32-bit signed input value, sign-extended and wrapped to element width
  function automatic logic [ELEM_BITS-1:0] to_elem(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[ELEM_BITS-1:0];
  endfunction

  // element value, sign-extended, low 32 bits
  function automatic logic [31:0] to_out32(logic [ELEM_BITS-1:0] x);
    logic signed [63:0] ext;
    ext = 64'(signed'(x));
    return ext[31:0];
  endfunction

endpackage

// ----- hdl/mmae_if.sv -----
// ----------------------------------------------------------------------------
// mmae_if
// valid/ready channels of the matrix engine: command input and result output
// ----------------------------------------------------------------------------
interface mmae_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [31:0] element_value;

  modport source (output valid, command, row_index, col_index, element_value,
                  input ready);
  modport sink (input valid, command, row_index, col_index, element_value,
                output ready);
endinterface

interface mmae_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] out_value;
  logic               last;

  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

// ----- hdl/matrix_multiply_add_engine_unit.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_add_engine_unit
// dense integer matrix engine: elementwise add, subtract or matrix product
// ----------------------------------------------------------------------------
// Load commands write one element of the left or right store. A run command
// walks the result row by row; each product element issues one store read per
// cycle per matrix over the inner dimension, then passes a read, a multiply
// and an accumulate stage, while add and subtract issue a single read per
// element. The single read port of each store and the one multiplier set the
// pace of a run. No new command is taken while a run is in progress; the
// result register lets the next command in once the last element of a run is
// waiting there. Stores come out of reset unwritten and need no clearing pass;
// reading an element never loaded gives no defined value.
// ----------------------------------------------------------------------------
module matrix_multiply_add_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mmae_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // command and result channels
  mmae_in_if.sink                      in_i,
  mmae_out_if.source                   out_o
);

  mmae_pkg::cfg_t                 cfg;
  mmae_pkg::mem_req_t             mem_req;
  logic [mmae_pkg::ELEM_BITS-1:0] left_rdata;
  logic [mmae_pkg::ELEM_BITS-1:0] right_rdata;

  // dimension and operation registers
  mmae_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // left matrix store, addressed row * MAX_DIM + col
  mmae_ram #(
    .WIDTH (mmae_pkg::ELEM_BITS),
    .DEPTH (mmae_pkg::DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_left),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr_left),
    .rdata_o (left_rdata)
  );

  // right matrix store, same layout
  mmae_ram #(
    .WIDTH (mmae_pkg::ELEM_BITS),
    .DEPTH (mmae_pkg::DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we_right),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr_right),
    .rdata_o (right_rdata)
  );

  // sequencer: writes on loads, read / combine / accumulate on runs
  mmae_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_i          (in_i),
    .out_o         (out_o),
    .mem_o         (mem_req),
    .left_rdata_i  (left_rdata),
    .right_rdata_i (right_rdata)
  );

endmodule

// ----- hdl/mmae_ram.sv -----
// ----------------------------------------------------------------------------
// mmae_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mmae_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mmae_cfg.sv -----
// ----------------------------------------------------------------------------
// mmae_cfg
// apb register file: dimensions and operation select
// ----------------------------------------------------------------------------
module mmae_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mmae_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mmae_pkg::cfg_t              cfg_o
);

  mmae_pkg::cfg_t              cfg_q;
  logic [mmae_pkg::REG_W-1:0]  reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mmae_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_rows  <= 4'd8;
      cfg_q.inner_size <= 4'd8;
      cfg_q.right_cols <= 4'd8;
      cfg_q.operation  <= mmae_pkg::OP_PROD;
    end else if (wr_en) begin
      case (reg_idx)
        mmae_pkg::REG_LEFT_ROWS:  cfg_q.left_rows  <= pwdata[3:0];
        mmae_pkg::REG_INNER_SIZE: cfg_q.inner_size <= pwdata[3:0];
        mmae_pkg::REG_RIGHT_COLS: cfg_q.right_cols <= pwdata[3:0];
        mmae_pkg::REG_OPERATION:  cfg_q.operation  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mmae_pkg::REG_LEFT_ROWS:  prdata = 32'(cfg_q.left_rows);
      mmae_pkg::REG_INNER_SIZE: prdata = 32'(cfg_q.inner_size);
      mmae_pkg::REG_RIGHT_COLS: prdata = 32'(cfg_q.right_cols);
      mmae_pkg::REG_OPERATION:  prdata = 32'(cfg_q.operation);
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/mmae_seq.sv -----
// ----------------------------------------------------------------------------
// mmae_seq
// command sequencer and multiply-accumulate datapath around the two stores
// ----------------------------------------------------------------------------
module mmae_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mmae_pkg::cfg_t                cfg_i,
  mmae_in_if.sink                       in_i,
  mmae_out_if.source                    out_o,
  output mmae_pkg::mem_req_t            mem_o,
  input  logic [mmae_pkg::ELEM_BITS-1:0] left_rdata_i,
  input  logic [mmae_pkg::ELEM_BITS-1:0] right_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } state_e;

  state_e state_q, state_d;

  logic [mmae_pkg::IDX_W-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic [mmae_pkg::DIM_W-1:0]     rows_q, rows_d, cols_q, cols_d, inner_q, inner_d;
  logic [1:0]                     op_q, op_d;
  logic                           rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic                           mul_v_q, mul_v_d, mul_last_q, mul_last_d;
  logic                           done_q, done_d;
  logic [mmae_pkg::ELEM_BITS-1:0] mul_q, mul_d, acc_q, acc_d;
  logic                           out_valid_q, out_valid_d;
  logic [2:0]                     out_row_q, out_row_d, out_col_q, out_col_d;
  logic [31:0]                    out_value_q, out_value_d;
  logic                           out_last_q, out_last_d;

  logic in_xfer, is_load, start, k_last, elem_last, emit;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign is_load    = in_xfer
                   && (in_i.command == mmae_pkg::CMD_LOAD_LEFT
                    || in_i.command == mmae_pkg::CMD_LOAD_RIGHT)
                   && (32'(in_i.row_index) < mmae_pkg::MAX_DIM)
                   && (32'(in_i.col_index) < mmae_pkg::MAX_DIM);
  assign start      = in_xfer && (in_i.command == mmae_pkg::CMD_RUN)
                   && (cfg_i.operation <= mmae_pkg::OP_PROD);

  assign k_last    = (op_q != mmae_pkg::OP_PROD)
                  || (mmae_pkg::DIM_W'(k_q) + mmae_pkg::DIM_W'(1) == inner_q);
  assign elem_last = (mmae_pkg::DIM_W'(i_q) + mmae_pkg::DIM_W'(1) == rows_q)
                  && (mmae_pkg::DIM_W'(j_q) + mmae_pkg::DIM_W'(1) == cols_q);
  assign emit      = (state_q == S_WAIT) && done_q && (!out_valid_q || out_o.ready);

  // store port requests
  always_comb begin
    mem_o.we_left  = is_load && (in_i.command == mmae_pkg::CMD_LOAD_LEFT);
    mem_o.we_right = is_load && (in_i.command == mmae_pkg::CMD_LOAD_RIGHT);
    mem_o.waddr    = mmae_pkg::elem_addr(mmae_pkg::IDX_W'(in_i.row_index),
                                         mmae_pkg::IDX_W'(in_i.col_index));
    mem_o.wdata    = mmae_pkg::to_elem(in_i.element_value);
    mem_o.re       = (state_q == S_ISSUE);
    if (op_q == mmae_pkg::OP_PROD) begin
      mem_o.raddr_left  = mmae_pkg::elem_addr(i_q, k_q);
      mem_o.raddr_right = mmae_pkg::elem_addr(k_q, j_q);
    end else begin
      mem_o.raddr_left  = mmae_pkg::elem_addr(i_q, j_q);
      mem_o.raddr_right = mmae_pkg::elem_addr(i_q, j_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    rows_d      = rows_q;
    cols_d      = cols_q;
    inner_d     = inner_q;
    op_d        = op_q;
    rd_v_d      = (state_q == S_ISSUE);
    rd_last_d   = k_last;
    mul_v_d     = rd_v_q;
    mul_last_d  = rd_last_q;
    done_d      = done_q;
    mul_d       = mul_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    // stage one: combine the two store words
    if (rd_v_q) begin
      case (op_q)
        mmae_pkg::OP_ADD: mul_d = left_rdata_i + right_rdata_i;
        mmae_pkg::OP_SUB: mul_d = left_rdata_i - right_rdata_i;
        default:          mul_d = left_rdata_i * right_rdata_i;
      endcase
    end

    // stage two: accumulate
    if (mul_v_q) begin
      acc_d  = acc_q + mul_q;
      done_d = mul_last_q;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          rows_d  = mmae_pkg::clamp_dim(cfg_i.left_rows);
          inner_d = mmae_pkg::clamp_dim(cfg_i.inner_size);
          cols_d  = (cfg_i.operation == mmae_pkg::OP_PROD)
                  ? mmae_pkg::clamp_dim(cfg_i.right_cols)
                  : mmae_pkg::clamp_dim(cfg_i.inner_size);
          op_d    = cfg_i.operation;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_d   = '0;
          done_d  = 1'b0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (k_last) begin
          state_d = S_WAIT;
        end else begin
          k_d = k_q + mmae_pkg::IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          out_row_d   = 3'(i_q);
          out_col_d   = 3'(j_q);
          out_value_d = mmae_pkg::to_out32(acc_q);
          out_last_d  = elem_last;
          acc_d       = '0;
          done_d      = 1'b0;
          k_d         = '0;
          if (mmae_pkg::DIM_W'(j_q) + mmae_pkg::DIM_W'(1) == cols_q) begin
            j_d = '0;
            i_d = i_q + mmae_pkg::IDX_W'(1);
          end else begin
            j_d = j_q + mmae_pkg::IDX_W'(1);
          end
          state_d = elem_last ? S_IDLE : S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      mul_v_q     <= mul_v_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and payload
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    rows_q      <= rows_d;
    cols_q      <= cols_d;
    inner_q     <= inner_d;
    op_q        <= op_d;
    rd_last_q   <= rd_last_d;
    mul_last_q  <= mul_last_d;
    mul_q       <= mul_d;
    acc_q       <= acc_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_value_q;
  assign out_o.last      = out_last_q;

endmodule

// ----- hdl/mmae_checker.sv -----
// ----------------------------------------------------------------------------
// mmae_checker
// port-level checks of the matrix engine, bound to the top level
// ----------------------------------------------------------------------------
module mmae_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_row_i,
  input logic [2:0]  out_col_i,
  input logic [31:0] out_value_i,
  input logic        out_last_i,
  input logic        pready_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_row_i)
      && $stable(out_col_i) && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // while a run still owes elements, no command is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("command input open in the middle of a run");

  // no result shows during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // register port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

endmodule

bind matrix_multiply_add_engine_unit mmae_checker u_mmae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_row_i   (out_o.out_row),
  .out_col_i   (out_o.out_col),
  .out_value_i (out_o.out_value),
  .out_last_i  (out_o.last),
  .pready_i    (pready)
);

// ----- sim/tb_matrix_multiply_add_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_matrix_multiply_add_engine_unit
// self-checking bench for the matrix engine: operand loads and add, subtract
// and product runs, with every result element compared against a behavioral
// copy of the engine kept by a scoreboard class
// ----------------------------------------------------------------------------
module tb_matrix_multiply_add_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // codes left unused by the package
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic [1:0] OP_NONE = 2'd3;

  // stimulus volume and the point where idling stops
  localparam int unsigned TARGET_ITEMS = 350;
  localparam int unsigned CALM_AFTER   = 290;

  // cycles to let pass when the last command may cause no result
  localparam int unsigned SHORT_DRAIN = 16;
  localparam int unsigned LONG_DRAIN  = 720;

  // one expected result element
  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } elem_t;

  // --------------------------------------------------------------------------
  // scoreboard: operand stores, register copy and queue of pending elements
  // --------------------------------------------------------------------------
  class mm_result_board;
    logic [mmae_pkg::ELEM_BITS-1:0] left_mat[mmae_pkg::DEPTH];
    logic [mmae_pkg::ELEM_BITS-1:0] right_mat[mmae_pkg::DEPTH];
    mmae_pkg::cfg_t                 regs;
    elem_t                          pending[$];
    int unsigned                    mismatches;
    int unsigned                    checked;
    int unsigned                    loads;
    int unsigned                    runs[4];

    function new();
      regs.left_rows  = 4'd8;
      regs.inner_size = 4'd8;
      regs.right_cols = 4'd8;
      regs.operation  = mmae_pkg::OP_PROD;
      foreach (left_mat[a]) begin
        left_mat[a]  = '0;
        right_mat[a] = '0;
      end
      mismatches = 0;
      checked    = 0;
      loads      = 0;
      foreach (runs[a]) runs[a] = 0;
    endfunction

    function void write_reg(logic [mmae_pkg::REG_W-1:0] idx, logic [31:0] v);
      case (idx)
        mmae_pkg::REG_LEFT_ROWS:  regs.left_rows  = v[3:0];
        mmae_pkg::REG_INNER_SIZE: regs.inner_size = v[3:0];
        mmae_pkg::REG_RIGHT_COLS: regs.right_cols = v[3:0];
        mmae_pkg::REG_OPERATION:  regs.operation  = v[1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything above the store size as the store size
    function int unsigned fit_dim(logic [3:0] d);
      if (d == 4'd0) return 1;
      if (32'(d) > mmae_pkg::MAX_DIM) return mmae_pkg::MAX_DIM;
      return 32'(d);
    endfunction

    // one accepted command: store update or full result of a run
    function void take_command(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                               logic signed [31:0] v);
      logic signed [63:0]             wide;
      logic [mmae_pkg::ELEM_BITS-1:0] acc;
      int unsigned                    rows, inner, cols, i, j, k;
      elem_t                          e;
      wide = v;
      case (cmd)
        mmae_pkg::CMD_LOAD_LEFT: begin
          left_mat[r * mmae_pkg::MAX_DIM + c] = wide[mmae_pkg::ELEM_BITS-1:0];
          loads++;
        end
        mmae_pkg::CMD_LOAD_RIGHT: begin
          right_mat[r * mmae_pkg::MAX_DIM + c] = wide[mmae_pkg::ELEM_BITS-1:0];
          loads++;
        end
        mmae_pkg::CMD_RUN: begin
          runs[regs.operation]++;
          if (regs.operation != OP_NONE) begin
            rows  = fit_dim(regs.left_rows);
            inner = fit_dim(regs.inner_size);
            cols  = (regs.operation == mmae_pkg::OP_PROD) ? fit_dim(regs.right_cols)
                                                           : inner;
            for (i = 0; i < rows; i++) begin
              for (j = 0; j < cols; j++) begin
                case (regs.operation)
                  mmae_pkg::OP_ADD:
                    acc = left_mat[i * mmae_pkg::MAX_DIM + j]
                        + right_mat[i * mmae_pkg::MAX_DIM + j];
                  mmae_pkg::OP_SUB:
                    acc = left_mat[i * mmae_pkg::MAX_DIM + j]
                        - right_mat[i * mmae_pkg::MAX_DIM + j];
                  default: begin
                    acc = '0;
                    for (k = 0; k < inner; k++) begin
                      acc += left_mat[i * mmae_pkg::MAX_DIM + k]
                           * right_mat[k * mmae_pkg::MAX_DIM + j];
                    end
                  end
                endcase
                wide    = $signed(acc);
                e.row   = 3'(i);
                e.col   = 3'(j);
                e.value = wide[31:0];
                e.last  = (i == rows - 1) && (j == cols - 1);
                pending = {pending, e};
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    task check_element(logic [2:0] r, logic [2:0] c, logic [31:0] v, logic lst);
      elem_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result (%0d,%0d) %h with nothing pending", r, c, v));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r !== e.row)
        report_mismatch($sformatf("out_row %0d, expected %0d", r, e.row));
      if (c !== e.col)
        report_mismatch($sformatf("out_col %0d, expected %0d", c, e.col));
      if (v !== e.value)
        report_mismatch($sformatf("(%0d,%0d) out_value %h, expected %h",
                                  e.row, e.col, v, e.value));
      if (lst !== e.last)
        report_mismatch($sformatf("(%0d,%0d) last %b, expected %b",
                                  e.row, e.col, lst, e.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mmae_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  mmae_in_if  cmd_ch ();
  mmae_out_if res_ch ();

  matrix_multiply_add_engine_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (cmd_ch),
    .out_o   (res_ch)
  );

  always #6 clk_i = ~clk_i;

  mm_result_board board = new();

  // idling switches, set per phase
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  // long hold-off request for the result side, taken by the sink process
  int unsigned hold_cycles = 0;
  // stimulus bookkeeping
  int unsigned items_sent = 0;
  bit          left_set[mmae_pkg::DEPTH];
  bit          right_set[mmae_pkg::DEPTH];

  // --------------------------------------------------------------------------
  // configuration port: all four registers in one burst of writes
  // --------------------------------------------------------------------------
  // setup and access phase per write; psel stays up between writes so that
  // no signal is assigned twice in one step
  task automatic apb_write(input logic [mmae_pkg::REG_W-1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mmae_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(idx, v);
  endtask

  task automatic set_config(input logic [3:0] lr, input logic [3:0] ir,
                            input logic [3:0] rc, input logic [1:0] op);
    apb_write(mmae_pkg::REG_LEFT_ROWS, 32'(lr));
    apb_write(mmae_pkg::REG_INNER_SIZE, 32'(ir));
    apb_write(mmae_pkg::REG_RIGHT_COLS, 32'(rc));
    apb_write(mmae_pkg::REG_OPERATION, 32'(op));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------
  // offer one command, optionally after an idle burst, and hold it until the
  // transfer; valid is left high for a back-to-back follower
  task automatic send_cmd(input logic [1:0] cmd, input logic [2:0] r,
                          input logic [2:0] c, input logic [31:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.command       <= cmd;
    cmd_ch.row_index     <= r;
    cmd_ch.col_index     <= c;
    cmd_ch.element_value <= v;
    do @(posedge clk_i); while (!cmd_ch.ready);
    // runs under the unknown operation are ignored like unknown commands
    if (cmd != CMD_NOP && !(cmd == mmae_pkg::CMD_RUN && board.regs.operation == OP_NONE))
      items_sent++;
    if (cmd == mmae_pkg::CMD_LOAD_LEFT) left_set[r * mmae_pkg::MAX_DIM + c] = 1'b1;
    if (cmd == mmae_pkg::CMD_LOAD_RIGHT) right_set[r * mmae_pkg::MAX_DIM + c] = 1'b1;
    board.take_command(cmd, r, c, v);
  endtask

  // wait until every pending element has come, then let the block go quiet
  task automatic settle(input bit slow);
    cmd_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (slow ? LONG_DRAIN : SHORT_DRAIN) @(posedge clk_i);
  endtask

  // element values lean toward the wrap-around corners
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // mostly small sizes, now and then zero, oversize or up to the full store
  function automatic logic [3:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 4'd0;
    if (sel == 1) return 4'($urandom_range(9, 15));
    if (sel <= 3) return 4'($urandom_range(4, 8));
    return 4'($urandom_range(1, 3));
  endfunction

  // load every operand entry that the next run reads: entries never written
  // always, the others refreshed at random
  task automatic fill_operands(input int unsigned rows, input int unsigned inner,
                               input int unsigned cols, input logic [1:0] op);
    int unsigned i, k, r_rows, r_cols;
    r_rows = (op == mmae_pkg::OP_PROD) ? inner : rows;
    r_cols = (op == mmae_pkg::OP_PROD) ? cols : inner;
    for (i = 0; i < rows; i++) begin
      for (k = 0; k < inner; k++) begin
        if (!left_set[i * mmae_pkg::MAX_DIM + k] || $urandom_range(0, 1) == 1)
          send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'(i), 3'(k), rand_elem());
      end
    end
    for (i = 0; i < r_rows; i++) begin
      for (k = 0; k < r_cols; k++) begin
        if (!right_set[i * mmae_pkg::MAX_DIM + k] || $urandom_range(0, 1) == 1)
          send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'(i), 3'(k), rand_elem());
      end
    end
  endtask

  // stray loads anywhere in the stores and unknown commands
  task automatic stray_cmd();
    if ($urandom_range(0, 3) == 0)
      send_cmd(CMD_NOP, 3'($urandom()), 3'($urandom()), $urandom());
    if ($urandom_range(0, 3) == 0)
      send_cmd($urandom_range(0, 1) ? mmae_pkg::CMD_LOAD_RIGHT : mmae_pkg::CMD_LOAD_LEFT,
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_elem());
  endtask

  // one configuration and a few runs; the full phase uses the whole store
  // and holds the result side off while the product streams out
  task automatic random_phase(input bit full);
    logic [3:0]  lr, ir, rc;
    logic [1:0]  op;
    int unsigned n_runs, sel;
    if (full) begin
      lr = 4'($urandom_range(8, 15));
      ir = 4'($urandom_range(8, 15));
      rc = 4'($urandom_range(8, 15));
      op = mmae_pkg::OP_PROD;
    end else begin
      lr  = pick_dim();
      ir  = pick_dim();
      rc  = pick_dim();
      sel = $urandom_range(0, 9);
      op  = (sel < 3) ? mmae_pkg::OP_ADD : (sel < 6) ? mmae_pkg::OP_SUB
          : (sel < 9) ? mmae_pkg::OP_PROD : OP_NONE;
    end
    // calm tail: no idling on either side
    gaps_on   = items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
    stalls_on = items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
    set_config(lr, ir, rc, op);
    n_runs = full ? 1 : $urandom_range(1, 3);
    repeat (n_runs) begin
      if (op != OP_NONE)
        fill_operands(board.fit_dim(lr), board.fit_dim(ir), board.fit_dim(rc), op);
      stray_cmd();
      if (full) hold_cycles = 1000;
      // row, column and value are don't-care on a run
      send_cmd(mmae_pkg::CMD_RUN, 3'($urandom()), 3'($urandom()), $urandom());
      // keep offering while the result side is held off
      if (full) begin
        repeat (3) send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)), rand_elem());
      end
    end
    settle(op == OP_NONE);
  endtask

  // --------------------------------------------------------------------------
  // result side: ready in random bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned span;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        span        = hold_cycles;
        hold_cycles = 0;
        res_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 14);
        res_ch.ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 16);
        res_ch.ready <= 1'b1;
      end
      repeat (span) @(posedge clk_i);
    end
  end

  // every result transfer is checked against the oldest pending element
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      board.check_element(res_ch.out_row, res_ch.out_col, res_ch.out_value, res_ch.last);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.command       <= CMD_NOP;
    cmd_ch.row_index     <= '0;
    cmd_ch.col_index     <= '0;
    cmd_ch.element_value <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // add wrapping past the largest positive value
    set_config(4'd1, 4'd1, 4'd1, mmae_pkg::OP_ADD);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd0, 3'd0, 32'h7fff_ffff);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd0, 3'd0, 32'h0000_0001);
    send_cmd(mmae_pkg::CMD_RUN, 3'd7, 3'd7, 32'h7fff_ffff);
    settle(1'b0);

    // subtract wrapping below the most negative value
    set_config(4'd1, 4'd1, 4'd1, mmae_pkg::OP_SUB);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd0, 3'd0, 32'h8000_0000);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd0, 3'd0, 32'h0000_0001);
    send_cmd(mmae_pkg::CMD_RUN, 3'd0, 3'd0, 32'h8000_0000);
    settle(1'b0);

    // zero dimensions act as one; product of minus one and the minimum
    set_config(4'd0, 4'd0, 4'd0, mmae_pkg::OP_PROD);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd0, 3'd0, 32'hffff_ffff);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd0, 3'd0, 32'h8000_0000);
    send_cmd(CMD_NOP, 3'd7, 3'd7, 32'hffff_ffff);
    send_cmd(mmae_pkg::CMD_RUN, 3'd0, 3'd0, 32'h0000_0000);
    settle(1'b0);

    // two-term accumulation that overflows
    set_config(4'd2, 4'd2, 4'd1, mmae_pkg::OP_PROD);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd0, 3'd1, 32'h7fff_ffff);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd1, 3'd0, 32'hffff_ffff);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd1, 3'd1, 32'h8000_0000);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd1, 3'd0, 32'h7fff_ffff);
    send_cmd(mmae_pkg::CMD_RUN, 3'd0, 3'd0, 32'h0000_0000);
    settle(1'b0);

    // far corner of both stores, then a run under the unknown operation
    set_config(4'd8, 4'd8, 4'd8, OP_NONE);
    send_cmd(mmae_pkg::CMD_LOAD_LEFT, 3'd7, 3'd7, 32'h0000_0000);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd7, 3'd7, 32'h7fff_ffff);
    send_cmd(mmae_pkg::CMD_LOAD_RIGHT, 3'd7, 3'd0, 32'hffff_ffff);
    send_cmd(mmae_pkg::CMD_RUN, 3'd0, 3'd0, 32'h0000_0000);
    settle(1'b1);

    // random phases, one of them full size with the long hold-off
    random_phase(1'b0);
    random_phase(1'b1);
    while (items_sent < TARGET_ITEMS) random_phase(1'b0);
    settle(1'b1);

    $display("covered %0d operand loads and runs: add %0d, subtract %0d, product %0d",
             board.loads, board.runs[mmae_pkg::OP_ADD], board.runs[mmae_pkg::OP_SUB],
             board.runs[mmae_pkg::OP_PROD]);
    $display("%0d runs under the unknown operation, %0d result elements compared, %0d mismatches",
             board.runs[OP_NONE], board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_matrix_multiply_add_engine_unit OK");
    end else begin
      $display("tb_matrix_multiply_add_engine_unit NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d elements pending", board.pending.size());
    $display("tb_matrix_multiply_add_engine_unit NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mmae_pkg.sv
hdl/mmae_if.sv
hdl/mmae_ram.sv
hdl/mmae_cfg.sv
hdl/mmae_seq.sv
hdl/matrix_multiply_add_engine_unit.sv
hdl/mmae_checker.sv
sim/tb_matrix_multiply_add_engine_unit.sv
